@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands shared by the matcher rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ACMC_CHECK(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ACMC_IMPLY(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/acmc_pkg.sv @@
// ----------------------------------------------------------------------------
// acmc_pkg
// shared codes and types of the active match counter
// ----------------------------------------------------------------------------
package acmc_pkg;

	// item op codes
	localparam logic [2:0] OP_PCHAR   = 3'd0;
	localparam logic [2:0] OP_BUILD   = 3'd1;
	localparam logic [2:0] OP_ENABLE  = 3'd2;
	localparam logic [2:0] OP_DISABLE = 3'd3;
	localparam logic [2:0] OP_TEXT    = 3'd4;

	// result status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_BADID  = 2'd2;
	localparam logic [1:0] ST_ORDER  = 2'd3;

	// shared arithmetic unit modes
	typedef enum logic [1:0] {
		U_ADD,
		U_ADD_SAT,
		U_SUB_FLOOR
	} unit_op_t;

endpackage

@@ rtl/core/acmc_unit.sv @@
// ----------------------------------------------------------------------------
// acmc_unit
// shared adder: plain add, saturating add, subtract floored at zero
// ----------------------------------------------------------------------------
module acmc_unit #(
	parameter int W        = 41,
	parameter int SAT_BITS = 40
) (
	input  acmc_pkg::unit_op_t mode,
	input  logic [W-1:0]       a,
	input  logic [W-1:0]       b,
	output logic [W-1:0]       y
);
	import acmc_pkg::*;

	localparam logic [W:0]   SAT_ONE = (W+1)'(1) << SAT_BITS;
	localparam logic [W-1:0] SAT_MAX = W'(SAT_ONE - (W+1)'(1));

	logic [W:0] sum;

	assign sum = {1'b0, a} + {1'b0, b};

	always_comb begin
		case (mode)
			U_ADD: begin
				y = sum[W-1:0];
			end
			U_ADD_SAT: begin
				// anything at or past the saturation bit clamps
				y = ((sum >> SAT_BITS) != '0) ? SAT_MAX : sum[W-1:0];
			end
			U_SUB_FLOOR: begin
				y = (a < b) ? '0 : a - b;
			end
			default: begin
				y = sum[W-1:0];
			end
		endcase
	end

endmodule

@@ rtl/core/aho_corasick_active_match_counter.sv @@
// ----------------------------------------------------------------------------
// aho_corasick_active_match_counter
// multi-pattern matcher with per-pattern enable, counting enabled matches
// ----------------------------------------------------------------------------
//  channel | dir | tdata                         | tuser   | tlast
//  s_*     | in  | symbol[4:0] pattern_id[14:5]  | op[2:0] | last of pattern/query
//  m_*     | out | match_total, status above it  | -       | -
//
//  after reset a clear pass zeroes the child table, counts and pattern flags; ready
//  stays low until it ends
//  a text char follows goto and fail steps, then sums counts along the fail chain
//  build walks the trie breadth first and sets the fail link of each child, then
//  enables every loaded pattern slot; one item at a time, a result waits in the
//  output register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module aho_corasick_active_match_counter #(
	parameter int NODES      = 4096,
	parameter int PATTERNS   = 1024,
	parameter int ALPHABET   = 26,
	parameter int TOTAL_BITS = 40
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [15:0]         s_tdata,   // symbol[4:0], pattern_id[14:5]
	input  logic [2:0]          s_tuser,   // op[2:0]
	input  logic                s_tlast,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [((TOTAL_BITS+2+7)/8)*8-1:0] m_tdata  // match_total, status
);
	import acmc_pkg::*;

	localparam int OUT_W = ((TOTAL_BITS+2+7)/8)*8;
	localparam int NW    = $clog2(NODES);
	localparam int SW    = $clog2(ALPHABET);
	localparam int PW    = (PATTERNS > 1) ? $clog2(PATTERNS) : 1;
	localparam int CN    = NODES * ALPHABET;
	localparam int CW    = $clog2(CN);
	localparam int CNTW  = $clog2(PATTERNS + 1);
	localparam int CLR_N = (CN > PATTERNS) ? CN : PATTERNS;
	localparam int CLRW  = $clog2(CLR_N);
	localparam int IDW   = ((PW > 10) ? PW : 10) + 1;
	localparam int UW0   = (TOTAL_BITS > NW + 1) ? TOTAL_BITS : NW + 1;
	localparam int UW    = (UW0 > CNTW) ? UW0 : CNTW;

	typedef enum logic [4:0] {
		S_IDLE, S_DEC, S_EMIT,
		S_PC_CHK, S_P_LAST,
		S_D_W, S_D_CW,
		S_T_WALK, S_T_WW, S_T_SUM, S_T_SW, S_T_END,
		S_B_POP, S_B_POPW, S_B_CH, S_B_CHK, S_B_WALK, S_B_WW, S_B_LINK, S_B_NEXT,
		S_E_RD, S_E_W, S_E_CW, S_E_NEXT
	} state_t;

	state_t state_q;

	// item fields
	logic [2:0]  op_q;
	logic [4:0]  sym_q;
	logic        last_q;
	logic [9:0]  id_q;

	// block state
	logic [1:0]            status_q;
	logic [TOTAL_BITS-1:0] res_q;
	logic [TOTAL_BITS-1:0] rt_q;
	logic [NW-1:0]         cursor_q;
	logic [NW:0]           nodes_q;
	logic [NW-1:0]         match_q;
	logic                  built_q;
	logic [NW-1:0]         t_q;
	logic [NW-1:0]         p_q;
	logic [NW-1:0]         c_q;
	logic [SW-1:0]         i_q;
	logic [NW:0]           head_q;
	logic [NW:0]           tail_q;
	logic [PW-1:0]         k_q;
	logic                  clearing_q;
	logic [CLRW-1:0]       clr_q;

	// output register
	logic                  ovalid_q;
	logic [TOTAL_BITS-1:0] ototal_q;
	logic [1:0]            ostatus_q;

	// memories
	logic [NW-1:0]   child_mem [0:CN-1];
	logic [NW-1:0]   fail_mem  [0:NODES-1];
	logic [CNTW-1:0] cnt_mem   [0:NODES-1];
	logic [NW-1:0]   pend_mem  [0:PATTERNS-1];
	logic [1:0]      flag_mem  [0:PATTERNS-1];  // [1] enabled, [0] loaded
	logic [NW-1:0]   queue_mem [0:NODES-1];

	logic [CW-1:0]   child_ra, child_wa;
	logic            child_we;
	logic [NW-1:0]   child_wd, child_rd;
	logic [NW-1:0]   fail_ra, fail_wa, fail_wd, fail_rd;
	logic            fail_we;
	logic [NW-1:0]   cnt_ra, cnt_wa;
	logic            cnt_we;
	logic [CNTW-1:0] cnt_wd, cnt_rd;
	logic [PW-1:0]   flag_ra, flag_wa;
	logic            flag_we, pend_we;
	logic [1:0]      flag_wd, flag_rd;
	logic [NW-1:0]   pend_wd, pend_rd;
	logic [NW-1:0]   q_wa, q_wd, q_rd;
	logic            q_we;

	// shared unit
	unit_op_t        u_mode;
	logic [UW-1:0]   u_a, u_b, u_y;

	// decode helpers
	logic            sym_ok, id_ok, want, dec_build, room;
	logic [SW-1:0]   symt;
	logic [IDW-1:0]  id_ext;
	logic [PW-1:0]   idx;
	logic [1:0]      st_last;

	function automatic logic [CW-1:0] caddr(input logic [NW-1:0] n, input logic [SW-1:0] s);
		return CW'(n) * CW'(ALPHABET) + CW'(s);
	endfunction

	assign sym_ok    = 6'(sym_q) < 6'(ALPHABET);
	assign symt      = sym_q[SW-1:0];
	assign id_ext    = IDW'(id_q);
	assign id_ok     = id_ext < IDW'(PATTERNS);
	assign idx       = id_ext[PW-1:0];
	assign want      = (op_q == OP_ENABLE);
	assign dec_build = (state_q == S_DEC) && (op_q == OP_BUILD) && !built_q;
	assign room      = nodes_q < (NW+1)'(NODES);
	// a bad id is reported only when the character itself was fine
	assign st_last   = (last_q && !id_ok && status_q == ST_OK) ? ST_BADID : status_q;

	assign s_tready  = (state_q == S_IDLE) && !clearing_q;
	assign m_tvalid  = ovalid_q;
	assign m_tdata   = OUT_W'({ostatus_q, ototal_q});

	acmc_unit #(
		.W        (UW),
		.SAT_BITS (TOTAL_BITS)
	) u_unit (
		.mode (u_mode),
		.a    (u_a),
		.b    (u_b),
		.y    (u_y)
	);

	// unit operand selection
	always_comb begin
		u_mode = U_ADD;
		u_a    = '0;
		u_b    = '0;
		case (state_q)
			S_PC_CHK: begin
				u_a = UW'(nodes_q);
				u_b = UW'(1);
			end
			S_T_SW: begin
				u_mode = U_ADD_SAT;
				u_a    = UW'(rt_q);
				u_b    = UW'(cnt_rd);
			end
			S_E_CW: begin
				u_a = UW'(cnt_rd);
				u_b = UW'(1);
			end
			S_D_CW: begin
				u_mode = want ? U_ADD : U_SUB_FLOOR;
				u_a    = UW'(cnt_rd);
				u_b    = UW'(1);
			end
			default: begin
				u_mode = U_ADD;
			end
		endcase
	end

	// memory addressing: address in one state, data in the next
	always_comb begin
		case (state_q)
			S_DEC:    child_ra = caddr(cursor_q, symt);
			S_B_CH:   child_ra = caddr(p_q, i_q);
			S_B_WALK: child_ra = caddr(t_q, i_q);
			S_T_WALK: child_ra = caddr(t_q, symt);
			default:  child_ra = caddr(t_q, symt);
		endcase
		fail_ra = (state_q == S_B_CH) ? p_q : t_q;
		cnt_ra  = (state_q == S_E_W || state_q == S_D_W) ? pend_rd : t_q;
		flag_ra = (state_q == S_E_RD) ? k_q : idx;

		child_we = clearing_q ? ((CLRW+1)'(clr_q) < (CLRW+1)'(CN))
		                      : (state_q == S_PC_CHK && child_rd == '0 && room);
		child_wa = clearing_q ? clr_q[CW-1:0] : caddr(cursor_q, symt);
		child_wd = clearing_q ? '0 : nodes_q[NW-1:0];

		fail_we = dec_build || (state_q == S_B_LINK);
		fail_wa = dec_build ? '0 : c_q;
		fail_wd = dec_build ? '0 : t_q;

		q_we = fail_we;
		q_wa = dec_build ? '0 : tail_q[NW-1:0];
		q_wd = dec_build ? '0 : c_q;

		cnt_we = clearing_q ? ((CLRW+1)'(clr_q) < (CLRW+1)'(NODES))
		                    : (state_q == S_E_CW || state_q == S_D_CW);
		cnt_wa = clearing_q ? clr_q[NW-1:0] : t_q;
		cnt_wd = clearing_q ? '0 : u_y[CNTW-1:0];

		pend_we = (state_q == S_P_LAST) && last_q && id_ok;
		pend_wd = cursor_q;

		flag_we = 1'b0;
		flag_wa = idx;
		flag_wd = 2'b01;
		if (clearing_q) begin
			flag_we = (CLRW+1)'(clr_q) < (CLRW+1)'(PATTERNS);
			flag_wa = clr_q[PW-1:0];
			flag_wd = 2'b00;
		end else begin
			case (state_q)
				S_P_LAST: begin
					flag_we = last_q && id_ok;
				end
				S_E_W: begin
					flag_we = flag_rd[0] && !flag_rd[1];
					flag_wa = k_q;
					flag_wd = 2'b11;
				end
				S_D_W: begin
					flag_we = flag_rd[0] && (flag_rd[1] != want);
					flag_wd = {want, 1'b1};
				end
				default: begin
					flag_we = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (child_we) child_mem[child_wa] <= child_wd;
		child_rd <= child_mem[child_ra];
	end

	always_ff @(posedge clk) begin
		if (fail_we) fail_mem[fail_wa] <= fail_wd;
		fail_rd <= fail_mem[fail_ra];
	end

	always_ff @(posedge clk) begin
		if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
		cnt_rd <= cnt_mem[cnt_ra];
	end

	always_ff @(posedge clk) begin
		if (pend_we) pend_mem[flag_wa] <= pend_wd;
		pend_rd <= pend_mem[flag_ra];
	end

	always_ff @(posedge clk) begin
		if (flag_we) flag_mem[flag_wa] <= flag_wd;
		flag_rd <= flag_mem[flag_ra];
	end

	always_ff @(posedge clk) begin
		if (q_we) queue_mem[q_wa] <= q_wd;
		q_rd <= queue_mem[head_q[NW-1:0]];
	end

	// payload of the output register
	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && (!ovalid_q || m_tready)) begin
			ototal_q  <= res_q;
			ostatus_q <= status_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			clearing_q <= 1'b1;
			clr_q      <= '0;
			ovalid_q   <= 1'b0;
			nodes_q    <= (NW+1)'(1);
			cursor_q   <= '0;
			match_q    <= '0;
			rt_q       <= '0;
			built_q    <= 1'b0;
			status_q   <= ST_OK;
			res_q      <= '0;
			op_q       <= '0;
			sym_q      <= '0;
			last_q     <= 1'b0;
			id_q       <= '0;
			t_q        <= '0;
			p_q        <= '0;
			c_q        <= '0;
			i_q        <= '0;
			head_q     <= '0;
			tail_q     <= '0;
			k_q        <= '0;
		end else begin
			// clear pass over the stores that reset to zero
			if (clearing_q) begin
				if (clr_q == CLRW'(CLR_N - 1)) begin
					clearing_q <= 1'b0;
				end
				clr_q <= clr_q + CLRW'(1);
			end

			// output register drains when the sink takes it
			if (m_tready && state_q != S_EMIT) begin
				ovalid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (s_tvalid && s_tready) begin
						op_q     <= s_tuser;
						sym_q    <= s_tdata[4:0];
						id_q     <= s_tdata[14:5];
						last_q   <= s_tlast;
						status_q <= ST_OK;
						res_q    <= '0;
						state_q  <= S_DEC;
					end
				end
				S_DEC: begin
					case (op_q)
						OP_PCHAR: begin
							if (built_q) begin
								status_q <= ST_ORDER;
								state_q  <= S_EMIT;
							end else if (!sym_ok) begin
								status_q <= ST_BADID;
								state_q  <= S_P_LAST;
							end else begin
								state_q <= S_PC_CHK;
							end
						end
						OP_BUILD: begin
							if (built_q) begin
								status_q <= ST_ORDER;
								state_q  <= S_EMIT;
							end else begin
								// root link and queue head written this cycle
								head_q  <= '0;
								tail_q  <= (NW+1)'(1);
								state_q <= S_B_POP;
							end
						end
						OP_ENABLE, OP_DISABLE: begin
							if (!built_q) begin
								status_q <= ST_ORDER;
								state_q  <= S_EMIT;
							end else if (!id_ok) begin
								status_q <= ST_BADID;
								state_q  <= S_EMIT;
							end else begin
								state_q <= S_D_W;
							end
						end
						OP_TEXT: begin
							if (!built_q) begin
								status_q <= ST_ORDER;
								state_q  <= S_EMIT;
							end else if (!sym_ok) begin
								// unknown letter drops back to root
								t_q     <= '0;
								match_q <= '0;
								state_q <= S_T_SUM;
							end else begin
								t_q     <= match_q;
								state_q <= S_T_WALK;
							end
						end
						default: begin
							state_q <= S_IDLE;
						end
					endcase
				end
				S_EMIT: begin
					if (!ovalid_q || m_tready) begin
						ovalid_q <= 1'b1;
						state_q  <= S_IDLE;
					end
				end

				// pattern load
				S_PC_CHK: begin
					if (child_rd == '0) begin
						if (room) begin
							cursor_q <= nodes_q[NW-1:0];
							nodes_q  <= u_y[NW:0];
						end else begin
							status_q <= ST_FULL;
						end
					end else begin
						cursor_q <= child_rd;
					end
					state_q <= S_P_LAST;
				end
				S_P_LAST: begin
					status_q <= st_last;
					if (last_q) begin
						cursor_q <= '0;
					end
					state_q <= (st_last != ST_OK) ? S_EMIT : S_IDLE;
				end

				// enable or disable one pattern
				S_D_W: begin
					if (!flag_rd[0]) begin
						status_q <= ST_BADID;
						state_q  <= S_EMIT;
					end else if (flag_rd[1] == want) begin
						state_q <= S_IDLE;
					end else begin
						t_q     <= pend_rd;
						state_q <= S_D_CW;
					end
				end
				S_D_CW: begin
					state_q <= S_IDLE;
				end

				// text: follow goto/fail, then sum counts along the fail chain
				S_T_WALK: begin
					state_q <= S_T_WW;
				end
				S_T_WW: begin
					if (t_q != '0 && child_rd == '0) begin
						t_q     <= fail_rd;
						state_q <= S_T_WALK;
					end else begin
						t_q     <= child_rd;
						match_q <= child_rd;
						state_q <= S_T_SUM;
					end
				end
				S_T_SUM: begin
					state_q <= S_T_SW;
				end
				S_T_SW: begin
					rt_q <= u_y[TOTAL_BITS-1:0];
					if (t_q == '0) begin
						state_q <= S_T_END;
					end else begin
						t_q     <= fail_rd;
						state_q <= S_T_SUM;
					end
				end
				S_T_END: begin
					if (last_q) begin
						res_q   <= rt_q;
						rt_q    <= '0;
						match_q <= '0;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_IDLE;
					end
				end

				// build: breadth-first fail links
				S_B_POP: begin
					if (head_q == tail_q) begin
						k_q     <= '0;
						state_q <= S_E_RD;
					end else begin
						head_q  <= head_q + (NW+1)'(1);
						state_q <= S_B_POPW;
					end
				end
				S_B_POPW: begin
					p_q     <= q_rd;
					i_q     <= '0;
					state_q <= S_B_CH;
				end
				S_B_CH: begin
					state_q <= S_B_CHK;
				end
				S_B_CHK: begin
					c_q <= child_rd;
					if (child_rd == '0) begin
						state_q <= S_B_NEXT;
					end else if (p_q == '0) begin
						t_q     <= '0;
						state_q <= S_B_LINK;
					end else begin
						t_q     <= fail_rd;
						state_q <= S_B_WALK;
					end
				end
				S_B_WALK: begin
					state_q <= S_B_WW;
				end
				S_B_WW: begin
					if (t_q != '0 && child_rd == '0) begin
						t_q     <= fail_rd;
						state_q <= S_B_WALK;
					end else begin
						t_q     <= child_rd;
						state_q <= S_B_LINK;
					end
				end
				S_B_LINK: begin
					tail_q  <= tail_q + (NW+1)'(1);
					state_q <= S_B_NEXT;
				end
				S_B_NEXT: begin
					if (i_q == SW'(ALPHABET - 1)) begin
						state_q <= S_B_POP;
					end else begin
						i_q     <= i_q + SW'(1);
						state_q <= S_B_CH;
					end
				end

				// build: enable every loaded pattern
				S_E_RD: begin
					state_q <= S_E_W;
				end
				S_E_W: begin
					if (flag_rd[0] && !flag_rd[1]) begin
						t_q     <= pend_rd;
						state_q <= S_E_CW;
					end else begin
						state_q <= S_E_NEXT;
					end
				end
				S_E_CW: begin
					state_q <= S_E_NEXT;
				end
				S_E_NEXT: begin
					if (k_q == PW'(PATTERNS - 1)) begin
						built_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						k_q     <= k_q + PW'(1);
						state_q <= S_E_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`ACMC_IMPLY(a_no_accept_clear, clearing_q, !s_tready, "item taken during clear pass")
	`ACMC_CHECK(a_nodes_bound, nodes_q <= (NW+1)'(NODES), "node count past table size")
	`ACMC_IMPLY(a_built_sticks, $past(built_q), built_q, "built flag dropped")
	`ACMC_IMPLY(a_bfs_order, state_q == S_B_POP, head_q <= tail_q, "queue head past tail")

endmodule
